// ===== rtl/sch_pkg.sv =====
// Shared types, command codes and constants for the signed coefficient histogram.
`timescale 1ns / 1ps

package sch_pkg;

  // Default sizing of the count table
  localparam int POSITIONS_DEF = 64;
  localparam int BINS_DEF      = 2048;

  // Depth of the queue between front and back (power of two)
  localparam int Q_DEPTH = 4;

  // Command codes on the cmd port
  localparam logic [1:0] CMD_INC  = 2'd0;
  localparam logic [1:0] CMD_SET  = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  // Position whose bins feed the running total
  localparam logic [5:0] TOTAL_POS = 6'd63;

  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;
  localparam logic [47:0] TOTAL_MAX = 48'hFFFF_FFFF_FFFF;

  // Classified operation
  typedef enum logic [1:0] {
    OP_INC,
    OP_SET,
    OP_READ
  } op_t;

  // One classified beat travelling from front to back
  typedef struct packed {
    op_t         op;
    logic        in_range;
    logic        is_total;
    logic [31:0] new_count;
  } item_t;

endpackage

// ===== rtl/sch_front.sv =====
// Front end: accepts a beat, classifies the command and forms the bin address.
`timescale 1ns / 1ps

module sch_front #(
  parameter int POSITIONS = sch_pkg::POSITIONS_DEF,
  parameter int BINS      = sch_pkg::BINS_DEF,
  parameter int AW        = $clog2(POSITIONS * 2 * BINS)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [1:0]          cmd,
  input  logic [5:0]          coef_index,
  input  logic                was_positive,
  input  logic [10:0]         magnitude,
  input  logic [31:0]         new_count,
  output logic                f_valid,
  output sch_pkg::item_t      f_item,
  output logic [AW-1:0]       f_addr
);

  sch_pkg::item_t item_next;
  logic [6:0]     row;
  logic [AW-1:0]  row_base;
  logic [AW-1:0]  addr_next;

  // Decode the command; the unused code behaves as a read
  always_comb begin
    item_next.new_count = new_count;
    item_next.in_range  = (int'(coef_index) < POSITIONS) && (int'(magnitude) < BINS);
    item_next.is_total  = (coef_index == sch_pkg::TOTAL_POS);
    case (cmd)
      sch_pkg::CMD_INC:  item_next.op = sch_pkg::OP_INC;
      sch_pkg::CMD_SET:  item_next.op = sch_pkg::OP_SET;
      sch_pkg::CMD_READ: item_next.op = sch_pkg::OP_READ;
      default:           item_next.op = sch_pkg::OP_READ;
    endcase
  end

  // Row is position and side; each row holds BINS counters
  assign row       = {coef_index, was_positive};
  assign row_base  = AW'(row) * AW'(BINS);
  assign addr_next = row_base + AW'(magnitude);

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else begin
      f_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_item <= item_next;
      f_addr <= addr_next;
    end
  end

endmodule

// ===== rtl/sch_queue.sv =====
// Short FIFO that decouples the front end from the read-modify-write back end.
`timescale 1ns / 1ps

module sch_queue #(
  parameter int AW = 18
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  push,
  input  sch_pkg::item_t                        push_item,
  input  logic [AW-1:0]                         push_addr,
  input  logic                                  pop,
  output logic                                  q_valid,
  output sch_pkg::item_t                        q_item,
  output logic [AW-1:0]                         q_addr,
  output logic [$clog2(sch_pkg::Q_DEPTH+1)-1:0] count
);

  localparam int PW = $clog2(sch_pkg::Q_DEPTH);
  localparam int CW = $clog2(sch_pkg::Q_DEPTH + 1);

  sch_pkg::item_t items [sch_pkg::Q_DEPTH];
  logic [AW-1:0]  addrs [sch_pkg::Q_DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;

  assign q_valid = (count != '0);
  assign q_item  = items[rd_ptr];
  assign q_addr  = addrs[rd_ptr];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PW'(1);
      if (pop)  rd_ptr <= rd_ptr + PW'(1);
      count <= count + CW'(push) - CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      items[wr_ptr] <= push_item;
      addrs[wr_ptr] <= push_addr;
    end
  end

  // No push into a full queue unless a beat leaves in the same cycle
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (push && (count == CW'(sch_pkg::Q_DEPTH))) |-> pop)
    else $error("queue overflow");

  // No pop from an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> (count != '0))
    else $error("queue underflow");

  // Fill level goes up by one on a push without a pop
  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + CW'(1)))
    else $error("queue count mismatch");

endmodule

// ===== rtl/sch_back.sv =====
// Back end: clears the count table, then runs read-modify-write with forwarding.
`timescale 1ns / 1ps

module sch_back #(
  parameter int POSITIONS = sch_pkg::POSITIONS_DEF,
  parameter int BINS      = sch_pkg::BINS_DEF,
  parameter int AW        = $clog2(POSITIONS * 2 * BINS)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  sch_pkg::item_t      q_item,
  input  logic [AW-1:0]       q_addr,
  output logic                pop,
  output logic                clearing,
  output logic                done,
  output logic [31:0]         bin_count,
  output logic [47:0]         total_blocks
);

  localparam int STORE_DEPTH = POSITIONS * 2 * BINS;
  localparam int TOT_W       = 33 + $clog2(BINS);
  localparam int EXT_W       = (TOT_W > 48) ? TOT_W : 48;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'b01,
    ST_RUN   = 2'b10
  } back_state_t;

  back_state_t    state;
  logic [AW-1:0]  clr_addr;

  logic [31:0]    mem [STORE_DEPTH];
  logic [31:0]    rdata;

  // Write stage
  logic           w_valid;
  sch_pkg::item_t w_item;
  logic [AW-1:0]  w_addr;
  logic           fwd_hit;
  logic [31:0]    fwd_data;
  logic [31:0]    w_old;
  logic [31:0]    w_nv;
  logic           w_we;

  logic [TOT_W-1:0] total;
  logic [TOT_W-1:0] total_next;
  logic [EXT_W-1:0] total_ext;
  logic [47:0]      total_sat;

  assign clearing = (state == ST_CLEAR);
  assign pop      = q_valid && (state == ST_RUN);

  // Clearing pass after reset, one entry per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(STORE_DEPTH - 1)) state <= ST_RUN;
        end
        ST_RUN:   state <= ST_RUN;
        default:  state <= ST_CLEAR;
      endcase
    end
  end

  // New count of the bin in the write stage
  always_comb begin
    w_old = fwd_hit ? fwd_data : rdata;
    case (w_item.op)
      sch_pkg::OP_INC:  w_nv = (w_old == sch_pkg::COUNT_MAX) ? w_old : w_old + 32'd1;
      sch_pkg::OP_SET:  w_nv = w_item.new_count;
      sch_pkg::OP_READ: w_nv = w_old;
      default:          w_nv = w_old;
    endcase
    w_we = w_valid && w_item.in_range;
  end

  // Table port: registered read, one write
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (w_we) begin
      mem[w_addr] <= w_nv;
    end
    rdata <= mem[q_addr];
  end

  // Read stage to write stage; forward when the bin was just written
  always_ff @(posedge clk) begin
    if (rst) begin
      w_valid <= 1'b0;
      fwd_hit <= 1'b0;
    end else begin
      w_valid <= pop;
      fwd_hit <= pop && w_we && q_item.in_range && (w_addr == q_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      w_item <= q_item;
      w_addr <= q_addr;
    end
    fwd_data <= w_nv;
  end

  // Running total of the last position, saturated on the way out
  always_comb begin
    total_next = total;
    if (w_we && w_item.is_total) begin
      total_next = total - TOT_W'(w_old) + TOT_W'(w_nv);
    end
    total_ext = EXT_W'(total_next);
    total_sat = (total_ext > EXT_W'(sch_pkg::TOTAL_MAX)) ? sch_pkg::TOTAL_MAX
                                                          : total_ext[47:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
      done  <= 1'b0;
    end else begin
      total <= total_next;
      done  <= w_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (w_valid) begin
      bin_count    <= w_item.in_range ? w_nv : 32'd0;
      total_blocks <= total_sat;
    end
  end

  // Nothing is taken from the queue while the table is being cleared
  a_no_pop_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> (!pop && !w_valid))
    else $error("beat processed during clearing pass");

  // Every beat in the write stage yields exactly one result next cycle
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    w_valid |=> done)
    else $error("result strobe missing");

  // A forward only follows a real table write of the same bin
  a_fwd_source: assert property (@(posedge clk) disable iff (rst)
    fwd_hit |-> ($past(w_we) && (w_addr == $past(q_addr))))
    else $error("forward without a matching write");

  // The total changes only on a write to the last position
  a_total_stable: assert property (@(posedge clk) disable iff (rst)
    !(w_we && w_item.is_total) |=> (total == $past(total)))
    else $error("total changed without a write");

endmodule

// ===== rtl/signed_coefficient_histogram.sv =====
// Top level of the signed coefficient histogram: front end, queue and back end.
//
//   channel   ports                                                 timing
//   command   start, busy, cmd, coef_index, was_positive,           beat taken when start
//             magnitude, new_count                                  high and busy low
//   result    done, bin_count, total_blocks                         one cycle, done high
//
// One command per cycle is sustained outside the clearing pass; a beat taken
// passes the front register, the queue, the table read and the result register.
// The rate is set by the table's read-modify-write, which forwards a bin written in
// the previous cycle into the next access of the same bin. After reset a clearing
// pass zeroes all POSITIONS*2*BINS entries (262144 at the defaults), with busy held
// high throughout. The receiver cannot stall; busy also rises if the front/back queue fills.
`timescale 1ns / 1ps

module signed_coefficient_histogram #(
  parameter int POSITIONS = sch_pkg::POSITIONS_DEF,
  parameter int BINS      = sch_pkg::BINS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  cmd,
  input  logic [5:0]  coef_index,
  input  logic        was_positive,
  input  logic [10:0] magnitude,
  input  logic [31:0] new_count,
  output logic        done,
  output logic [31:0] bin_count,
  output logic [47:0] total_blocks
);

  localparam int AW = $clog2(POSITIONS * 2 * BINS);
  localparam int CW = $clog2(sch_pkg::Q_DEPTH + 1);

  logic           accept;
  logic           f_valid;
  sch_pkg::item_t f_item;
  logic [AW-1:0]  f_addr;
  logic           q_valid;
  sch_pkg::item_t q_item;
  logic [AW-1:0]  q_addr;
  logic [CW-1:0]  q_count;
  logic           pop;
  logic           clearing;

  // Hold off new beats while clearing or when the queue could not take them
  assign busy   = clearing ||
                  ((CW + 1)'(q_count) + (CW + 1)'(f_valid) >= (CW + 1)'(sch_pkg::Q_DEPTH));
  assign accept = start && !busy;

  sch_front #(
    .POSITIONS (POSITIONS),
    .BINS      (BINS),
    .AW        (AW)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .cmd          (cmd),
    .coef_index   (coef_index),
    .was_positive (was_positive),
    .magnitude    (magnitude),
    .new_count    (new_count),
    .f_valid      (f_valid),
    .f_item       (f_item),
    .f_addr       (f_addr)
  );

  sch_queue #(
    .AW (AW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (f_valid),
    .push_item (f_item),
    .push_addr (f_addr),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_addr    (q_addr),
    .count     (q_count)
  );

  sch_back #(
    .POSITIONS (POSITIONS),
    .BINS      (BINS),
    .AW        (AW)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_addr       (q_addr),
    .pop          (pop),
    .clearing     (clearing),
    .done         (done),
    .bin_count    (bin_count),
    .total_blocks (total_blocks)
  );

endmodule
